// File: rtl/arp_pkg.sv
// package for the aarch64 relocation patcher
// holds relocation mode codes, status codes and instruction field constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

    // relocation modes
    localparam logic [2:0] MODE_ABS64     = 3'd0;
    localparam logic [2:0] MODE_BRANCH26  = 3'd1;
    localparam logic [2:0] MODE_ADRP      = 3'd2;
    localparam logic [2:0] MODE_PAGEOFF   = 3'd3;
    localparam logic [2:0] MODE_GOT_OFF   = 3'd4;
    localparam logic [2:0] MODE_GOT_ADD   = 3'd5;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_ALIGN  = 2'd2,
        ST_BADGOT = 2'd3
    } t_status;

    // instruction field constants
    localparam logic [31:0] LDST_UIMM_MASK = 32'h3B00_0000;
    localparam logic [31:0] LDST_UIMM_OP   = 32'h3900_0000;
    localparam logic [31:0] IMM12_KEEP     = 32'hFFC0_03FF;
    localparam logic [7:0]  LDR_X_TOP      = 8'hF9;
    localparam logic [7:0]  LDR_W_TOP      = 8'hB9;
    localparam logic [7:0]  ADD_X_TOP      = 8'h91;
    localparam logic [7:0]  ADD_W_TOP      = 8'h11;
    localparam logic [4:0]  ADRP_OP_MID    = 5'b10000;

endpackage : arp_pkg

`default_nettype wire

// File: rtl/arp_calc.sv
// combinational relocation patch logic for one item
// depends on arp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arp_calc
    import arp_pkg::*;
(
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_insn,
    input  wire logic [63:0] i_place,
    input  wire logic [63:0] i_target,
    output logic      [63:0] o_patched,
    output t_status          o_status
);

    logic [63:0] delta;
    logic        br_in_range;
    logic [20:0] page_delta;
    logic [1:0]  scale_log2;
    logic [11:0] lo12;
    logic [11:0] lo_mask;
    logic [11:0] imm12;
    logic [31:0] off_word;
    logic [7:0]  top_byte;

    // branch displacement and range check: bits 63:27 must be a sign extension
    assign delta       = i_target - i_place;
    assign br_in_range = (&delta[63:27]) || (~|delta[63:27]);

    // adrp page delta, only the low 21 bits matter
    assign page_delta = i_target[32:12] - i_place[32:12];

    // page offset scale selection
    assign lo12     = i_target[11:0];
    assign top_byte = i_insn[31:24];
    always_comb begin
        scale_log2 = 2'd0;
        if (i_mode == MODE_GOT_OFF) begin
            scale_log2 = (i_insn[31:30] == 2'b11) ? 2'd3 : 2'd2;
        end else if ((i_insn & LDST_UIMM_MASK) == LDST_UIMM_OP) begin
            scale_log2 = i_insn[31:30];
        end
    end

    assign lo_mask  = 12'((13'd1 << scale_log2) - 13'd1);
    assign imm12    = lo12 >> scale_log2;
    assign off_word = (i_insn & IMM12_KEEP) | {10'd0, imm12, 10'd0};

    // result selection per mode
    always_comb begin
        o_patched = {32'd0, i_insn};
        o_status  = ST_OK;
        case (i_mode)
            MODE_ABS64: begin
                o_patched = i_target;
            end
            MODE_BRANCH26: begin
                if (!br_in_range) begin
                    o_status = ST_RANGE;
                end else if (delta[1:0] != 2'd0) begin
                    o_status = ST_ALIGN;
                end else begin
                    o_patched = {32'd0, i_insn[31:26], delta[27:2]};
                end
            end
            MODE_ADRP: begin
                o_patched = {32'd0, 1'b1, page_delta[1:0], ADRP_OP_MID,
                             page_delta[20:2], i_insn[4:0]};
            end
            MODE_PAGEOFF, MODE_GOT_OFF: begin
                if ((lo12 & lo_mask) != 12'd0) begin
                    o_status = ST_ALIGN;
                end else begin
                    o_patched = {32'd0, off_word};
                end
            end
            MODE_GOT_ADD: begin
                if (top_byte == LDR_X_TOP) begin
                    o_patched = {32'd0, ADD_X_TOP, i_insn[23:22], lo12, i_insn[9:0]};
                    o_patched[23:22] = 2'b00;
                end else if (top_byte == LDR_W_TOP) begin
                    o_patched = {32'd0, ADD_W_TOP, i_insn[23:22], lo12, i_insn[9:0]};
                    o_patched[23:22] = 2'b00;
                end else begin
                    o_status = ST_BADGOT;
                end
            end
            default: begin
                o_patched = {32'd0, i_insn};
            end
        endcase
    end

endmodule : arp_calc

`default_nettype wire

// File: rtl/aarch64_reloc_patcher.sv
// top level of the aarch64 relocation patcher
// depends on arp_pkg and arp_calc
//
// usage:
//   command channel: raise i_start with i_mode, i_insn, i_place and i_target;
//   the transfer happens at the rising edge where i_start is high and o_busy
//   is low. o_busy is always low, so one item can be taken every cycle.
//   result channel: o_done is high for exactly one cycle with o_patched and
//   o_status; the result transfers at the edge that ends that cycle.
//   the result passes the input register, the patch logic and the result
//   register in that order. throughput: one item per cycle, set by the single
//   pass through the patch logic.
//   items are independent and come out in order.
//   reset: synchronous, active low i_rst_n clears both valid flags; no result
//   is shown in the cycle after reset.
//   the receiver cannot stall: a result not taken in its cycle is gone.
`timescale 1ns / 1ps
`default_nettype none

module aarch64_reloc_patcher
    import arp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_insn,
    input  wire logic [63:0] i_place,
    input  wire logic [63:0] i_target,
    output logic             o_done,
    output logic      [63:0] o_patched,
    output logic      [1:0]  o_status
);

    logic        r_in_valid;
    logic [2:0]  r_mode;
    logic [31:0] r_insn;
    logic [63:0] r_place;
    logic [63:0] r_target;
    logic        r_out_valid;
    logic [63:0] r_patched;
    t_status     r_status;
    logic [63:0] n_patched;
    t_status     n_status;

    // never holds off a command
    assign o_busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_mode   <= i_mode;
            r_insn   <= i_insn;
            r_place  <= i_place;
            r_target <= i_target;
        end
    end

    // patch logic
    arp_calc u_calc (
        .i_mode    (r_mode),
        .i_insn    (r_insn),
        .i_place   (r_place),
        .i_target  (r_target),
        .o_patched (n_patched),
        .o_status  (n_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_patched <= n_patched;
            r_status  <= n_status;
        end
    end

    assign o_done    = r_out_valid;
    assign o_patched = r_patched;
    assign o_status  = r_status;

`ifndef ASSERT_OFF
    // every transfer produces exactly one result, through the input and result registers
    a_done_follows_start: assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n) && $past(i_rst_n, 2)) |-> (o_done == $past(i_start, 2)))
        else $error("result strobe does not match accepted command");

    // no result right after reset
    a_no_done_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_done)
        else $error("result strobe after reset");

    // error results return the original word with upper bits clear
    a_error_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (o_patched[63:32] == 32'd0))
        else $error("error result has nonzero upper bits");
`endif

endmodule : aarch64_reloc_patcher

`default_nettype wire

// File: verif/arp_checker.sv
// result checker for the aarch64 relocation patcher testbench
// watches the command and result channels, predicts each patch and compares in order
// depends on arp_pkg
`timescale 1ns / 1ps

module arp_checker
    import arp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [31:0] i_insn,
    input  wire logic [63:0] i_place,
    input  wire logic [63:0] i_target,
    input  wire logic        i_done,
    input  wire logic [63:0] i_patched,
    input  wire logic [1:0]  i_status,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_flagged
);

    typedef struct packed {
        logic [63:0] word;
        t_status     status;
    } t_patch;

    // expected patches, oldest first
    t_patch expected_patches[$];

    // write a page offset into imm12, scaled, or flag a misaligned offset
    function automatic logic [31:0] fill_offset(input logic [31:0] insn,
                                                input logic [11:0] lo,
                                                input logic [1:0]  scale_log2,
                                                output t_status    st);
        logic [11:0] mask;
        logic [11:0] imm;
        mask = (12'd1 << scale_log2) - 12'd1;
        imm  = lo >> scale_log2;
        if ((lo & mask) != 12'd0) begin
            st = ST_ALIGN;
            return insn;
        end
        st = ST_OK;
        return (insn & IMM12_KEEP) | ({20'd0, imm} << 10);
    endfunction

    // patched word and status for one relocation
    function automatic t_patch predict_patch(input logic [2:0]  mode,
                                             input logic [31:0] insn,
                                             input logic [63:0] place,
                                             input logic [63:0] target);
        t_patch      r;
        logic [63:0] delta;
        logic [63:0] page_delta;
        logic [20:0] page_imm;
        logic [1:0]  scale_log2;
        logic [31:0] word;
        t_status     st;
        r.word   = {32'd0, insn};
        r.status = ST_OK;
        case (mode)
            MODE_ABS64: begin
                r.word = target;
            end
            MODE_BRANCH26: begin
                delta = target - place;
                if (delta + 64'h0800_0000 >= 64'h1000_0000) begin
                    r.status = ST_RANGE;
                end else if (delta[1:0] != 2'b00) begin
                    r.status = ST_ALIGN;
                end else begin
                    r.word = {32'd0, insn[31:26], delta[27:2]};
                end
            end
            MODE_ADRP: begin
                page_delta = ({target[63:12], 12'd0} - {place[63:12], 12'd0}) >> 12;
                page_imm   = page_delta[20:0];
                r.word = {32'd0, 1'b1, page_imm[1:0], ADRP_OP_MID, page_imm[20:2],
                          insn[4:0]};
            end
            MODE_PAGEOFF: begin
                // only load/store unsigned-offset forms scale by access size
                scale_log2 = ((insn & LDST_UIMM_MASK) == LDST_UIMM_OP) ? insn[31:30] : 2'd0;
                word     = fill_offset(insn, target[11:0], scale_log2, st);
                r.word   = {32'd0, word};
                r.status = st;
            end
            MODE_GOT_OFF: begin
                scale_log2 = (insn[31:30] == 2'b11) ? 2'd3 : 2'd2;
                word     = fill_offset(insn, target[11:0], scale_log2, st);
                r.word   = {32'd0, word};
                r.status = st;
            end
            MODE_GOT_ADD: begin
                if (insn[31:24] == LDR_X_TOP) begin
                    r.word = {32'd0, ADD_X_TOP, 2'b00, target[11:0], insn[9:0]};
                end else if (insn[31:24] == LDR_W_TOP) begin
                    r.word = {32'd0, ADD_W_TOP, 2'b00, target[11:0], insn[9:0]};
                end else begin
                    r.status = ST_BADGOT;
                end
            end
            default: begin
                // undefined modes pass the word through
            end
        endcase
        return r;
    endfunction

    // predict on each command transfer, compare on each result transfer
    always @(posedge i_clk) begin : monitor
        t_patch want;
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_checked    = 0;
            o_flagged    = 0;
        end else begin
            if (i_start && !i_busy) begin
                want = predict_patch(i_mode, i_insn, i_place, i_target);
                expected_patches = {expected_patches, want};
                if (want.status != ST_OK) o_flagged++;
            end
            if (i_done) begin
                if (expected_patches.size() == 0) begin
                    $error("result with no transfer pending: patched %h status %0d",
                           i_patched, i_status);
                    o_fail_count++;
                end else begin
                    want = expected_patches.pop_front();
                    o_checked++;
                    if (i_patched !== want.word) begin
                        $error("patched: expected %h, actual %h", want.word, i_patched);
                        o_fail_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_patches.size();
    end

endmodule : arp_checker

// File: verif/tb_aarch64_reloc_patcher.sv
// testbench top for the aarch64 relocation patcher
// drives directed and random relocations with random gaps and gives the verdict
// depends on arp_pkg, aarch64_reloc_patcher and arp_checker
`timescale 1ns / 1ps

module tb_aarch64_reloc_patcher;
    import arp_pkg::*;

    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 4;
    localparam int IDLE_PCT     = 38;

    // codes the block leaves undefined
    localparam logic [2:0] MODE_UNDEF_LO = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic [2:0]  i_mode;
    logic [31:0] i_insn;
    logic [63:0] i_place;
    logic [63:0] i_target;
    logic        o_busy;
    logic        o_done;
    logic [63:0] o_patched;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int checked_count;
    int flagged_count;
    int sent_per_mode[8];
    bit idle_on;

    aarch64_reloc_patcher dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .o_busy    (o_busy),
        .i_mode    (i_mode),
        .i_insn    (i_insn),
        .i_place   (i_place),
        .i_target  (i_target),
        .o_done    (o_done),
        .o_patched (o_patched),
        .o_status  (o_status)
    );

    arp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_mode       (i_mode),
        .i_insn       (i_insn),
        .i_place      (i_place),
        .i_target     (i_target),
        .i_done       (o_done),
        .i_patched    (o_patched),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked_count),
        .o_flagged    (flagged_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one command transfer
    task automatic send_reloc(input logic [2:0] mode, input logic [31:0] insn,
                              input logic [63:0] place, input logic [63:0] target);
        @(negedge i_clk);
        i_start  = 1'b1;
        i_mode   = mode;
        i_insn   = insn;
        i_place  = place;
        i_target = target;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        sent_per_mode[mode]++;
    endtask

    // sender gap, with junk on the fields
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_start  = 1'b0;
            i_mode   = 3'($urandom);
            i_insn   = $urandom;
            i_place  = rand64();
            i_target = rand64();
        end
    endtask

    // each cycle is idle with the given chance
    task automatic maybe_idle();
        while (idle_on && $urandom_range(99) < IDLE_PCT) hold_off(1);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // random relocation, mostly well formed for its mode
    task automatic random_reloc(output bit defined);
        logic [2:0]  mode;
        logic [31:0] insn;
        logic [63:0] place;
        logic [63:0] target;
        logic [27:0] reach;
        int          pick;
        mode   = ($urandom_range(99) < 8) ? 3'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI))
                                          : 3'($urandom_range(MODE_ABS64, MODE_GOT_ADD));
        insn   = $urandom;
        place  = rand64();
        target = rand64();
        reach  = 28'($urandom);
        pick   = $urandom_range(99);
        case (mode)
            MODE_BRANCH26: begin
                if (pick < 70) reach[1:0] = 2'b00;
                if (pick < 85) target = place + {{36{reach[27]}}, reach};
            end
            MODE_ADRP: begin
                if (pick < 50) target = place + {{36{reach[27]}}, reach};
            end
            MODE_PAGEOFF, MODE_GOT_OFF: begin
                if (pick < 30) insn[31:24] = LDR_X_TOP;
                else if (pick < 60) insn = (insn & ~LDST_UIMM_MASK) | LDST_UIMM_OP;
                if ($urandom_range(99) < 75) target[2:0] = 3'b000;
            end
            MODE_GOT_ADD: begin
                if (pick < 40) insn[31:24] = LDR_X_TOP;
                else if (pick < 80) insn[31:24] = LDR_W_TOP;
            end
            default: begin
            end
        endcase
        send_reloc(mode, insn, place, target);
        defined = (mode <= MODE_GOT_ADD);
    endtask

    initial begin : stimulus
        logic [63:0] base;
        int          defined_sent;
        bit          defined;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_mode   = MODE_ABS64;
        i_insn   = '0;
        i_place  = '0;
        i_target = '0;
        idle_on  = 1'b1;
        defined_sent = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: field extremes and every special case
        send_reloc(MODE_ABS64, 32'h0, 64'h0, '1);
        send_reloc(MODE_ABS64, '1, '1, 64'h0);
        base = rand64();
        send_reloc(MODE_BRANCH26, 32'h9400_0000, base, base + 64'h07FF_FFFC);
        maybe_idle();
        send_reloc(MODE_BRANCH26, 32'h1400_0000, base, base - 64'h0800_0000);
        send_reloc(MODE_BRANCH26, 32'h9400_0000, base, base + 64'h0800_0000);
        send_reloc(MODE_BRANCH26, 32'h9400_0000, base, base - 64'h0800_0004);
        send_reloc(MODE_BRANCH26, 32'h9400_0000, base, base + 64'h2);
        send_reloc(MODE_BRANCH26, '1, base, base);
        maybe_idle();
        send_reloc(MODE_ADRP, '1, 64'h0, '1);
        send_reloc(MODE_ADRP, 32'h0, '1, 64'h0);
        send_reloc(MODE_PAGEOFF, {LDR_X_TOP, 24'h40_0000}, base, 64'hFF8);
        send_reloc(MODE_PAGEOFF, {LDR_X_TOP, 24'h40_0000}, base, 64'h004);
        send_reloc(MODE_PAGEOFF, 32'h0, base, '1);
        send_reloc(MODE_PAGEOFF, 32'h3940_0000, base, '1);
        maybe_idle();
        send_reloc(MODE_GOT_OFF, {LDR_X_TOP, 24'h40_0000}, base, 64'hFF8);
        send_reloc(MODE_GOT_OFF, {LDR_W_TOP, 24'h40_0000}, base, 64'hFFC);
        send_reloc(MODE_GOT_OFF, {LDR_X_TOP, 24'h40_0000}, base, 64'h004);
        send_reloc(MODE_GOT_ADD, {LDR_X_TOP, 24'hFF_FFFF}, base, '1);
        send_reloc(MODE_GOT_ADD, {LDR_W_TOP, 24'h00_0000}, base, 64'hABC);
        send_reloc(MODE_GOT_ADD, {ADD_X_TOP, 24'h12_3456}, base, '1);
        send_reloc(MODE_UNDEF_LO, '1, base, '1);
        send_reloc(MODE_UNDEF_HI, 32'h0, base, 64'h0);

        // random part, with a pause to empty the pipe and a stretch with no gaps
        while (defined_sent < RANDOM_ITEMS) begin
            if (defined_sent == 100) drain();
            idle_on = !(defined_sent >= 150 && defined_sent < 250);
            maybe_idle();
            random_reloc(defined);
            if (defined) defined_sent++;
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $write("relocations sent: abs64 %0d, branch26 %0d, adrp %0d, pageoff %0d, ",
               sent_per_mode[MODE_ABS64], sent_per_mode[MODE_BRANCH26],
               sent_per_mode[MODE_ADRP], sent_per_mode[MODE_PAGEOFF]);
        $display("got pageoff %0d, got add %0d, undefined %0d",
                 sent_per_mode[MODE_GOT_OFF], sent_per_mode[MODE_GOT_ADD],
                 sent_per_mode[MODE_UNDEF_LO] + sent_per_mode[MODE_UNDEF_HI]);
        $display("results checked: %0d, of which %0d carried a range, alignment or got error",
                 checked_count, flagged_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule : tb_aarch64_reloc_patcher
